### hw/rtl/oaht_pkg.sv
package oaht_pkg;

   localparam int CHUNK = 7;
   localparam int TOTAL_W = 17;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY_KEY = 3'd1,
      ST_FULL      = 3'd2,
      ST_PRESENT   = 3'd3,
      ST_NO_INSERT = 3'd4,
      ST_NOT_FOUND = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      REG_SLOT_COUNT  = 2'd0,
      REG_HASH_SELECT = 2'd1,
      REG_PROBE_MODE  = 2'd2
   } reg_index_type;

   typedef enum logic [0:0] {
      OP_INSERT = 1'b0,
      OP_LOOKUP = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_HASH1,
      S_HASH2,
      S_PROBE,
      S_CHECK,
      S_DONE
   } state_type;

endpackage

### hw/rtl/open_addressing_hash_table.sv
// Steps from request to result valid: two 28-step serial modulo passes (S_HASH1,
// S_HASH2, S_PROBE), then S_CHECK reads each probed slot, then S_DONE loads the result
// register. An empty key or a full table skips S_CHECK.
// Throughput: one request at a time, the next accepted once the result is registered;
// a result still waiting holds the next one in its last state.
// Reset (synchronous, active high) empties all slots, clears counters, size 256, modes 0.
module open_addressing_hash_table #(
   parameter int TABLE_DEPTH = 256,
   parameter int KEY_DIGITS  = 16,
   parameter int VALUE_BITS  = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: key_digits[KEY_DIGITS*4-1:0], key_len[4:0], value_in, zero pad
   input  logic [((KEY_DIGITS*4+5+VALUE_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: req_type
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: status[2:0], value_out, probes[8:0], probe total[16:0], zero pad
   output logic [((3+VALUE_BITS+9+17+7)/8)*8-1:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [8:0]   csr_data
);
   import oaht_pkg::*;

   localparam int KB  = KEY_DIGITS * 4;
   localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SW  = $clog2(TABLE_DEPTH + 1);
   localparam int NCH = (KEY_DIGITS + CHUNK - 1) / CHUNK;
   localparam int HW  = CHUNK * 4;
   localparam int OW  = ((3 + VALUE_BITS + 9 + 17 + 7) / 8) * 8;

   // ---- configuration
   logic [8:0] size_reg_ff;
   logic       hsel_ff, pmode_ff;
   assign csr_ready = !reset;
   always_ff @(posedge clock) begin
      if (reset) begin
         size_reg_ff <= 9'd256;
         hsel_ff     <= 1'b0;
         pmode_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SLOT_COUNT:  size_reg_ff <= csr_data;
            REG_HASH_SELECT: hsel_ff     <= csr_data[0];
            REG_PROBE_MODE:  pmode_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [SW-1:0] size_eff;
   always_comb begin
      if (size_reg_ff == 9'd0) size_eff = SW'(1);
      else if ({23'd0, size_reg_ff} > TABLE_DEPTH) size_eff = SW'(TABLE_DEPTH);
      else size_eff = SW'(size_reg_ff);
   end

   // ---- request fields
   logic [KB-1:0]         in_key;
   logic [4:0]            in_len_raw, in_len;
   logic [VALUE_BITS-1:0] in_val;
   assign in_key     = req_tdata[KB-1:0];
   assign in_len_raw = req_tdata[KB+4:KB];
   assign in_val     = req_tdata[KB+5+VALUE_BITS-1:KB+5];
   assign in_len     = (in_len_raw > 5'(KEY_DIGITS)) ? 5'(KEY_DIGITS) : in_len_raw;

   logic [KB-1:0] in_key_m;
   always_comb begin
      for (int i = 0; i < KEY_DIGITS; i++)
         in_key_m[i*4 +: 4] = (5'(i) < in_len) ? in_key[i*4 +: 4] : 4'd0;
   end

   // both raw hashes: the low chunk, and independent chunk extracts XORed together
   logic [HW-1:0] last_raw, chunk_raw;
   always_comb begin
      logic [KB+HW-1:0] ext;
      logic [6:0]       sh;
      ext = {{HW{1'b0}}, in_key_m};
      sh = '0;
      last_raw = in_key_m[HW-1:0];
      chunk_raw = '0;
      for (int c = 0; c < NCH; c++) begin
         if (5'(c * CHUNK) < in_len) begin
            if (in_len - 5'(c * CHUNK) >= 5'(CHUNK)) begin
               sh = 7'((in_len - 5'(c * CHUNK) - 5'(CHUNK)) * 4);
               chunk_raw = chunk_raw ^ HW'(ext >> sh);
            end else begin
               chunk_raw = chunk_raw ^ in_key_m[HW-1:0] &
                  HW'((HW'(1) << (7'(in_len - 5'(c * CHUNK)) * 4)) - HW'(1));
            end
         end
      end
   end

   // ---- request registers
   logic                  op_ff;
   logic [KB-1:0]         key_ff;
   logic [4:0]            len_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [HW-1:0]         h1_raw_ff, h2_raw_ff;
   logic [SW-1:0]         size_ff;
   logic                  pm_ff;

   state_type state_ff, state_in;

   // ---- shared modulo unit
   logic           mod_start, mod_done;
   logic [HW-1:0]  mod_dividend;
   logic [SW-1:0]  mod_rem;
   oaht_mod_unit #(.DW(HW), .MW(SW)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(mod_dividend),
      .divisor(size_ff), .done(mod_done), .remainder(mod_rem)
   );

   // ---- slot store
   logic [AW-1:0]         pos_ff, pos_in;
   logic [KB-1:0]         rd_key;
   logic [4:0]            rd_len;
   logic [VALUE_BITS-1:0] rd_value;
   logic                  wr_en;
   oaht_slot_store #(.DEPTH(TABLE_DEPTH), .KW(KB), .LW(5), .VW(VALUE_BITS)) u_store (
      .clock(clock), .reset(reset), .rd_addr(pos_ff), .rd_key(rd_key),
      .rd_len(rd_len), .rd_value(rd_value), .wr_en(wr_en), .wr_addr(pos_ff),
      .wr_key(key_ff), .wr_len(len_ff), .wr_value(val_ff)
   );

   logic [SW-1:0]         h1_ff, h1_in, step_ff, step_in;
   logic [SW-1:0]         cnt_ff, cnt_in;
   logic [SW-1:0]         used_ff, used_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [2:0]            st_ff, st_in;
   logic [VALUE_BITS-1:0] found_ff, found_in;
   logic [8:0]            prb_ff, prb_in;
   logic                  out_v_ff, out_v_in;
   logic [OW-1:0]         rsp_data_ff, rsp_data_in;
   logic                  chk_ff;
   logic                  req_acc;
   logic [SW:0]           pos_sum;
   logic [TOTAL_W:0]      tsum;

   assign req_acc = req_tvalid && req_tready;
   assign req_tready = !reset && (state_ff == S_IDLE);

   always_comb begin
      state_in  = state_ff;
      h1_in     = h1_ff;
      step_in   = step_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      used_in   = used_ff;
      total_in  = total_ff;
      st_in     = st_ff;
      found_in  = found_ff;
      prb_in    = prb_ff;
      out_v_in  = out_v_ff;
      rsp_data_in = rsp_data_ff;
      mod_start = 1'b0;
      mod_dividend = h1_raw_ff;
      wr_en     = 1'b0;
      pos_sum   = {1'b0, SW'(pos_ff)} + {1'b0, step_ff};
      tsum      = {1'b0, total_ff} + (TOTAL_W+1)'(cnt_ff);
      if (out_v_ff && rsp_tready) out_v_in = 1'b0;
      case (state_ff)
         S_IDLE: if (req_acc) state_in = S_HASH1;
         S_HASH1: begin
            mod_start = 1'b1;
            state_in  = S_HASH2;
         end
         S_HASH2: if (mod_done) begin
            h1_in = mod_rem;
            mod_start = 1'b1;
            mod_dividend = h2_raw_ff;
            state_in = S_PROBE;
         end
         S_PROBE: if (mod_done) begin
            step_in = !pm_ff ? SW'(1) : (mod_rem == '0) ? SW'(1) : mod_rem;
            pos_in  = AW'(h1_ff);
            cnt_in  = '0;
            found_in = '0;
            prb_in   = '0;
            if (len_ff == 5'd0) begin
               st_in = ST_EMPTY_KEY;
               state_in = S_DONE;
            end else if (op_ff == OP_INSERT && used_ff >= size_ff) begin
               st_in = ST_FULL;
               state_in = S_DONE;
            end else begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // slot data is checked only while chk_ff is set, after the address settled
            state_in = S_CHECK;
            if (chk_ff) begin
               if (op_ff == OP_INSERT && rd_len == 5'd0) begin
                  wr_en = 1'b1;
                  used_in = used_ff + SW'(1);
                  total_in = tsum > (TOTAL_W+1)'(TOTAL_MAX) ? TOTAL_MAX : tsum[TOTAL_W-1:0];
                  st_in = ST_OK;
                  state_in = S_DONE;
               end else if (rd_len == len_ff && rd_key == key_ff) begin
                  if (op_ff == OP_INSERT) st_in = ST_PRESENT;
                  else begin
                     st_in = ST_OK;
                     found_in = rd_value;
                     prb_in = 9'(cnt_ff);
                  end
                  state_in = S_DONE;
               end else if (cnt_ff + SW'(1) >= size_ff) begin
                  st_in = (op_ff == OP_LOOKUP) ? ST_NOT_FOUND :
                          (pm_ff ? ST_NO_INSERT : ST_FULL);
                  state_in = S_DONE;
               end else begin
                  cnt_in = cnt_ff + SW'(1);
                  pos_in = (pos_sum >= {1'b0, size_ff}) ? AW'(pos_sum - {1'b0, size_ff})
                                                        : AW'(pos_sum);
               end
            end
         end
         S_DONE: begin
            // wait here while the previous result is still held
            if (!out_v_ff || rsp_tready) begin
               out_v_in = 1'b1;
               rsp_data_in = OW'({total_ff, prb_ff, found_ff, st_ff});
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) chk_ff <= 1'b0;
      else chk_ff <= (state_ff == S_CHECK) && !chk_ff && state_in == S_CHECK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         total_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         total_ff <= total_in;
         out_v_ff <= out_v_in;
      end
      h1_ff <= h1_in;
      step_ff <= step_in;
      pos_ff <= pos_in;
      cnt_ff <= cnt_in;
      st_ff <= st_in;
      found_ff <= found_in;
      prb_ff <= prb_in;
      rsp_data_ff <= rsp_data_in;
      if (req_acc) begin
         op_ff     <= req_tuser;
         key_ff    <= in_key_m;
         len_ff    <= in_len;
         val_ff    <= in_val;
         h1_raw_ff <= hsel_ff ? last_raw : chunk_raw;
         h2_raw_ff <= hsel_ff ? chunk_raw : last_raw;
         size_ff   <= size_eff;
         pm_ff     <= pmode_ff;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---- checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= SW'(TABLE_DEPTH)) else $error("used count beyond depth");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_tready) else $error("ready while busy");
   a_write_once: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (state_ff == S_DONE)) else $error("write outside insert end");
   a_total_mono: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> total_ff >= $past(total_ff)) else $error("total dropped");
endmodule

### hw/rtl/oaht_mod_unit.sv
// Restoring modulo: one quotient bit per cycle.
module oaht_mod_unit #(
   parameter int DW = 28,
   parameter int MW = 9
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [MW-1:0] divisor,
   output logic          done,
   output logic [MW-1:0] remainder
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] num_ff, num_in;
   logic [MW:0]   rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [MW:0]   trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[MW-1:0], num_ff[DW-1]};
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, divisor}) rem_in = trial - {1'b0, divisor};
         else rem_in = trial;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[MW-1:0];
endmodule

### hw/rtl/oaht_slot_store.sv
// Slot memories. Lengths carry per-slot valid bits; keys/values need none.
module oaht_slot_store #(
   parameter int DEPTH = 256,
   parameter int KW = 64,
   parameter int LW = 5,
   parameter int VW = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [KW-1:0]            rd_key,
   output logic [LW-1:0]            rd_len,
   output logic [VW-1:0]            rd_value,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [KW-1:0]            wr_key,
   input  logic [LW-1:0]            wr_len,
   input  logic [VW-1:0]            wr_value
);
   logic [KW-1:0] key_mem [DEPTH];
   logic [VW-1:0] val_mem [DEPTH];
   logic [LW-1:0] len_mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic          vld_rd_ff;
   logic [LW-1:0] len_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_value;
         len_mem[wr_addr] <= wr_len;
      end
      rd_key    <= key_mem[rd_addr];
      rd_value  <= val_mem[rd_addr];
      len_rd_ff <= len_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         if (wr_en) vld_ff[wr_addr] <= 1'b1;
         vld_rd_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_len = vld_rd_ff ? len_rd_ff : '0;
endmodule

### tb/sv/tb_open_addressing_hash_table.sv
module tb_open_addressing_hash_table;
   import oaht_pkg::*;

   localparam int DEPTH   = 256;
   localparam int DIGITS  = 16;
   localparam int SDATA_W = ((DIGITS*4+5+64+7)/8)*8;
   localparam int MDATA_W = ((3+64+9+17+7)/8)*8;
   localparam int DRAIN   = 800;

   typedef struct {
      op_type      op;
      logic [63:0] key;
      logic [4:0]  len;
      logic [63:0] val;
   } hash_req_type;

   typedef struct {
      status_type  status;
      logic [63:0] value;
      logic [8:0]  probes;
      logic [16:0] total;
   } table_rsp_type;

   typedef struct {
      logic [63:0] key;
      logic [4:0]  len;
   } key_ref_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [SDATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [MDATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_data = '0;

   open_addressing_hash_table dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // shadow table
   logic [63:0] tbl_key [DEPTH];
   logic [4:0]  tbl_len [DEPTH];
   logic [63:0] tbl_val [DEPTH];
   int          used_slots = 0;
   int          probe_sum = 0;
   logic [8:0]  cfg_size = 9'd256;
   logic        cfg_last7 = 1'b0;
   logic        cfg_double = 1'b0;

   hash_req_type  pending_q[$];
   table_rsp_type expected_q[$];
   key_ref_type   key_pool[$];
   hash_req_type  drv_item;
   int         errors = 0;
   bit         quiet = 0;
   bit         hold_req = 0;

   initial forever #6 clock = ~clock;

   initial begin
      for (int i = 0; i < DEPTH; i++) tbl_len[i] = '0;
   end

   function automatic logic [63:0] nib_mask(int n);
      if (n >= 16) return '1;
      return (64'd1 << (4*n)) - 64'd1;
   endfunction

   function automatic int hash_tail(logic [63:0] k, int len, int size);
      return int'((k & nib_mask(len < CHUNK ? len : CHUNK)) % size);
   endfunction

   function automatic int hash_xor(logic [63:0] k, int len, int size);
      logic [63:0] acc;
      int n;
      acc = '0;
      for (int start = 0; start < len; start += CHUNK) begin
         n = (len - start) < CHUNK ? (len - start) : CHUNK;
         acc ^= (k >> (4*(len - start - n))) & nib_mask(n);
      end
      return int'(acc % size);
   endfunction

   // expected response for one accepted request; updates the shadow table
   function automatic void predict_table(hash_req_type r);
      table_rsp_type e;
      int len, size, h1, h2, stp, p;
      logic [63:0] k;
      len = r.len > DIGITS ? DIGITS : int'(r.len);
      k = r.key & nib_mask(len);
      size = cfg_size == 0 ? 1 : (cfg_size > DEPTH ? DEPTH : int'(cfg_size));
      h1 = cfg_last7 ? hash_tail(k, len, size) : hash_xor(k, len, size);
      h2 = cfg_last7 ? hash_xor(k, len, size) : hash_tail(k, len, size);
      if (h2 == 0) h2 = 1;
      stp = cfg_double ? h2 : 1;
      e.value = '0;
      e.probes = '0;
      if (len == 0) begin
         e.status = ST_EMPTY_KEY;
      end else if (r.op == OP_INSERT) begin
         if (used_slots >= size) begin
            e.status = ST_FULL;
         end else begin
            e.status = cfg_double ? ST_NO_INSERT : ST_FULL;
            for (int c = 0; c < size; c++) begin
               p = (h1 + c*stp) % size;
               if (tbl_len[p] == 0) begin
                  tbl_key[p] = k;
                  tbl_len[p] = 5'(len);
                  tbl_val[p] = r.val;
                  used_slots++;
                  probe_sum += c;
                  if (probe_sum > 131071) probe_sum = 131071;
                  e.status = ST_OK;
                  break;
               end
               if (tbl_len[p] == len && tbl_key[p] == k) begin
                  e.status = ST_PRESENT;
                  break;
               end
            end
         end
      end else begin
         e.status = ST_NOT_FOUND;
         for (int c = 0; c < size; c++) begin
            p = (h1 + c*stp) % size;
            if (tbl_len[p] == len && tbl_key[p] == k) begin
               e.status = ST_OK;
               e.value = tbl_val[p];
               e.probes = 9'(c);
               break;
            end
         end
      end
      e.total = 17'(probe_sum);
      expected_q.insert(expected_q.size(), e);
   endfunction

   function automatic hash_req_type rand_req();
      hash_req_type r;
      key_ref_type kr;
      int pick;
      r.op = $urandom_range(0, 1) ? OP_LOOKUP : OP_INSERT;
      r.val = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (key_pool.size() > 0 && pick < 55) begin
         kr = key_pool[$urandom_range(0, key_pool.size()-1)];
         r.len = kr.len;
         r.key = kr.key;
         // junk above the key length must not matter
         if ($urandom_range(0, 2) == 0) r.key |= {$urandom, $urandom} & ~nib_mask(kr.len);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 4) r.len = 5'd0;
         else if (pick < 10) r.len = 5'($urandom_range(17, 31));
         else if (pick < 75) r.len = 5'($urandom_range(1, 8));
         else r.len = 5'($urandom_range(9, 16));
         r.key = {$urandom, $urandom};
         if ($urandom_range(0, 1)) r.key &= nib_mask(r.len);
         if (r.op == OP_INSERT && r.len != 0) begin
            kr.key = r.key & nib_mask(r.len);
            kr.len = r.len > DIGITS ? 5'(DIGITS) : r.len;
            key_pool.insert(key_pool.size(), kr);
         end
      end
      return r;
   endfunction

   // request driver
   int src_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_table(drv_item);
         if (!(req_tvalid && !req_tready)) begin
            if (src_gap > 0) begin
               src_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               drv_item = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= SDATA_W'({drv_item.val, drv_item.len, drv_item.key});
               req_tuser <= drv_item.op;
               if (!quiet && $urandom_range(0, 3) == 0) src_gap = $urandom_range(1, 3);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response back-pressure
   int sink_gap = 0;
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done = 1;
         hold_left = 2000;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (sink_gap > 0) begin
         sink_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 4) == 0) sink_gap = $urandom_range(1, 3);
      end
   end

   // response checker
   always @(posedge clock) begin
      table_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (rsp_tdata[2:0] !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_tdata[2:0]);
               errors++;
            end
            if (rsp_tdata[66:3] !== e.value) begin
               $error("value_out: expected %h, actual %h", e.value, rsp_tdata[66:3]);
               errors++;
            end
            if (rsp_tdata[75:67] !== e.probes) begin
               $error("probes: expected %0d, actual %0d", e.probes, rsp_tdata[75:67]);
               errors++;
            end
            if (rsp_tdata[92:76] !== e.total) begin
               $error("probe total: expected %0d, actual %0d", e.total, rsp_tdata[92:76]);
               errors++;
            end
         end
      end
   end

   task automatic csr_write(reg_index_type idx, logic [8:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_SLOT_COUNT:  cfg_size = data;
         REG_HASH_SELECT: cfg_last7 = data[0];
         REG_PROBE_MODE:  cfg_double = data[0];
         default: ;
      endcase
   endtask

   task automatic push_req(op_type op, logic [63:0] key, logic [4:0] len, logic [63:0] val);
      hash_req_type r;
      r.op = op;
      r.key = key;
      r.len = len;
      r.val = val;
      pending_q.insert(pending_q.size(), r);
   endtask

   task automatic wait_idle();
      wait (pending_q.size() == 0 && !req_tvalid && expected_q.size() == 0);
      repeat (DRAIN) @(posedge clock);
   endtask

   int ph_size[10]   = '{0, 1, 4, 7, 16, 37, 300, 255, 256, 256};
   int ph_last7[10]  = '{0, 1, 0, 1, 0, 1, 0, 1, 0, 1};
   int ph_double[10] = '{0, 1, 1, 0, 1, 1, 0, 1, 1, 0};
   int ph_count[10]  = '{40, 40, 80, 80, 150, 150, 150, 200, 150, 150};

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed requests at reset settings
      push_req(OP_INSERT, '1, 5'd16, '1);
      push_req(OP_LOOKUP, '1, 5'd16, '0);
      push_req(OP_INSERT, '0, 5'd1, '0);
      push_req(OP_LOOKUP, '0, 5'd1, '1);
      push_req(OP_INSERT, '1, 5'd0, 64'd7);
      push_req(OP_LOOKUP, '0, 5'd0, '0);
      push_req(OP_INSERT, '1, 5'd31, 64'd5);
      push_req(OP_LOOKUP, '1, 5'd20, '0);
      push_req(OP_INSERT, 64'hABCDEF0123456789, 5'd3, 64'd1);
      push_req(OP_LOOKUP, 64'h0000000000000789, 5'd3, '0);
      push_req(OP_LOOKUP, 64'h1234, 5'd4, '0);
      push_req(OP_INSERT, 64'h1234567, 5'd7, 64'h8000000000000001);
      push_req(OP_INSERT, 64'h1234567, 5'd8, 64'h2);
      push_req(OP_LOOKUP, 64'h1234567, 5'd7, '0);
      push_req(OP_LOOKUP, 64'h1234567, 5'd8, '0);
      // same home slot, different keys
      push_req(OP_INSERT, 64'h01, 5'd2, 64'h11);
      push_req(OP_INSERT, 64'h101, 5'd3, 64'h22);
      push_req(OP_LOOKUP, 64'h101, 5'd3, '0);
      push_req(OP_INSERT, 64'h101, 5'd3, 64'h33);
      wait_idle();

      for (int ph = 0; ph < 10; ph++) begin
         csr_write(REG_SLOT_COUNT, 9'(ph_size[ph]));
         csr_write(REG_HASH_SELECT, 9'(ph_last7[ph]));
         csr_write(REG_PROBE_MODE, 9'(ph_double[ph]));
         if (ph == 4) hold_req = 1;
         if (ph >= 8) quiet = 1;
         for (int i = 0; i < ph_count[ph]; i++) pending_q.insert(pending_q.size(), rand_req());
         wait_idle();
      end

      if (errors == 0 && expected_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #30000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
